// File: design/aes_pkg.sv
`default_nettype none
package aes_pkg;

  localparam int unsigned Rounds = 10;
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegKeyHigh = 1'b0;
  localparam logic [CfgIdxW-1:0] RegKeyLow = 1'b1;
  localparam logic [7:0] GfPoly = 8'h1b;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return v[7] ? ({v[6:0], 1'b0} ^ GfPoly) : {v[6:0], 1'b0};
  endfunction

  // byte i of the block at bits 127-8i
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(4*c+r) -: 8] = sbox(s[127-8*(4*((c+r)%4)+r) -: 8]);
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_cols(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127-32*c -: 8];
      a1 = s[119-32*c -: 8];
      a2 = s[111-32*c -: 8];
      a3 = s[103-32*c -: 8];
      t[127-32*c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      t[119-32*c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      t[111-32*c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      t[103-32*c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    return t;
  endfunction

  function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] t, w0, w1, w2, w3;
    t = {sbox(k[23:16]) ^ rc, sbox(k[15:8]), sbox(k[7:0]), sbox(k[31:24])};
    w0 = k[127:96] ^ t;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] r);
    logic [7:0] v;
    v = 8'h01;
    for (int i = 1; i < 11; i++) begin
      if (4'(i) < r) v = xtime(v);
    end
    return v;
  endfunction

endpackage
`default_nettype wire

// File: design/aes_round.sv
`default_nettype none
module aes_round #(
  parameter logic [3:0] RoundNum = 4'd1
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [127:0] state_in,
  input  wire logic [127:0] key_in,
  output logic      [127:0] state_out,
  output logic      [127:0] key_out
);
  logic [127:0] k_new, s_ss, s_mix;

  assign k_new = aes_pkg::next_key(key_in, aes_pkg::rcon(RoundNum));
  assign s_ss = aes_pkg::sub_shift(state_in);
  assign s_mix = (RoundNum == 4'(aes_pkg::Rounds)) ? s_ss : aes_pkg::mix_cols(s_ss);

  always_ff @(posedge clk) begin
    if (en) begin
      state_out <= s_mix ^ k_new;
      key_out <= k_new;
    end
  end
endmodule
`default_nettype wire

// File: design/aes128_block_encrypt.sv
`default_nettype none
// channel   signals                                   direction
// input     in_valid, in_ready, plain_high/low        into block
// output    out_valid, out_ready, cipher_high/low     out of block
// config    cfg_valid, cfg_ready, cfg_index, cfg_data into block
// one item per cycle unless out_ready stalls the output; add-key stage plus ten round stages
// each round stage expands its own round key next to the data, so keys travel with items
// a stall on the output holds every stage up to the first empty slot; a bubble is filled while stalled
// reset clears valid bits and both key registers
module aes128_block_encrypt (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [63:0]                plain_high,
  input  wire logic [63:0]                plain_low,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic      [63:0]                cipher_high,
  output logic      [63:0]                cipher_low,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [aes_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [63:0]                cfg_data
);
  localparam int unsigned NumRounds = aes_pkg::Rounds;

  logic [63:0] key_high, key_low;
  logic [NumRounds:0] vld;
  logic [NumRounds:0] adv;
  logic [127:0] st [NumRounds+1];
  logic [127:0] kk [NumRounds+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        aes_pkg::RegKeyHigh: key_high <= cfg_data;
        aes_pkg::RegKeyLow: key_low <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage i advances when its slot is free or emptying
  always_comb begin
    adv[NumRounds] = !vld[NumRounds] || out_ready;
    for (int i = NumRounds - 1; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      for (int i = 1; i <= NumRounds; i++) begin
        if (adv[i]) vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      st[0] <= {plain_high, plain_low} ^ {key_high, key_low};
      kk[0] <= {key_high, key_low};
    end
  end

  for (genvar g = 1; g <= NumRounds; g++) begin : g_round
    aes_round #(.RoundNum(4'(g))) u_round (
      .clk(clk),
      .en(adv[g]),
      .state_in(st[g-1]),
      .key_in(kk[g-1]),
      .state_out(st[g]),
      .key_out(kk[g])
    );
  end

  assign out_valid = vld[NumRounds];
  assign cipher_high = st[NumRounds][127:64];
  assign cipher_low = st[NumRounds][63:0];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cipher_high) && $stable(cipher_low))
    else $error("output item changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("pipeline blocked with empty output");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    vld[NumRounds-1] && !vld[NumRounds] |=> vld[NumRounds])
    else $error("item lost before last stage");
endmodule
`default_nettype wire
